### rtl/hpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg: shared types and constants of the heap priority queue
// Sizes, request and status codes, controller states, the datapath command
// and status bundles, and the ordering compare.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int CAPACITY   = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	// child index width, holds 2*(CAPACITY-1)+2
	localparam int CHILD_W    = ADDR_W + 2;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_RESP
	} state_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INS_START,
		OP_DEL_START,
		OP_REJ_FULL,
		OP_REJ_EMPTY,
		OP_UP_READ,
		OP_UP_STEP,
		OP_DN_LOAD,
		OP_DN_READ,
		OP_DN_STEP,
		OP_PLACE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic rsp_load;
	} hpq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic last_one;
		logic at_root;
		logic up_move;
		logic dn_leaf;
		logic dn_move;
	} hpq_stat_t;

	// true when x belongs strictly above y (mode 0 min on top, 1 max on top)
	function automatic logic above(input logic signed [DATA_WIDTH-1:0] x,
			input logic signed [DATA_WIDTH-1:0] y, input logic mode);
		above = mode ? (x > y) : (x < y);
	endfunction

endpackage

### rtl/hpq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_req_if / hpq_rsp_if: request and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface hpq_req_if;
	import hpq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic signed [DATA_WIDTH-1:0] data_value;

	modport source (output valid, output req_type, output data_value, input ready);
	modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface hpq_rsp_if;
	import hpq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] top_value;
	logic [CNT_W-1:0]             entry_total;
	logic                         is_empty;
	logic [1:0]                   status;

	modport source (output valid, output top_value, output entry_total,
			output is_empty, output status, input ready);
	modport sink   (input valid, input top_value, input entry_total,
			input is_empty, input status, output ready);
endinterface

### rtl/hpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ctrl: sequencer of the heap priority queue
// Takes a request, walks the sift loop a level at a time (read, then compare) through the
// datapath commands, and hands the result to the output register.
// ----------------------------------------------------------------------------
module hpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_type,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output hpq_pkg::hpq_cmd_t cmd,
	input  hpq_pkg::hpq_stat_t stat
);
	import hpq_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd.op       = OP_NONE;
		cmd.rsp_load = 1'b0;
		req_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_type == REQ_INSERT) begin
						if (stat.full) begin
							cmd.op    = OP_REJ_FULL;
							state_nxt = S_RESP;
						end else begin
							cmd.op    = OP_INS_START;
							state_nxt = S_UP_RD;
						end
					end else begin
						if (stat.empty) begin
							cmd.op    = OP_REJ_EMPTY;
							state_nxt = S_RESP;
						end else begin
							cmd.op    = OP_DEL_START;
							state_nxt = stat.last_one ? S_RESP : S_DN_LOAD;
						end
					end
				end
			end
			S_UP_RD: begin
				if (stat.at_root) begin
					cmd.op    = OP_PLACE;
					state_nxt = S_RESP;
				end else begin
					cmd.op    = OP_UP_READ;
					state_nxt = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_move) begin
					cmd.op    = OP_UP_STEP;
					state_nxt = S_UP_RD;
				end else begin
					cmd.op    = OP_PLACE;
					state_nxt = S_RESP;
				end
			end
			S_DN_LOAD: begin
				cmd.op    = OP_DN_LOAD;
				state_nxt = S_DN_RD;
			end
			S_DN_RD: begin
				if (stat.dn_leaf) begin
					cmd.op    = OP_PLACE;
					state_nxt = S_RESP;
				end else begin
					cmd.op    = OP_DN_READ;
					state_nxt = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_move) begin
					cmd.op    = OP_DN_STEP;
					state_nxt = S_DN_RD;
				end else begin
					cmd.op    = OP_PLACE;
					state_nxt = S_RESP;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.rsp_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/hpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_dp: datapath of the heap priority queue
// Heap memory with one write and two registered read ports, the moving value
// and its hole index, the entry count, a copy of the root and the result
// register.
// ----------------------------------------------------------------------------
module hpq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hpq_pkg::hpq_cmd_t            cmd,
	output hpq_pkg::hpq_stat_t           stat,
	input  logic signed [hpq_pkg::DATA_WIDTH-1:0] req_data,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	output logic signed [hpq_pkg::DATA_WIDTH-1:0] rsp_top_value,
	output logic [hpq_pkg::CNT_W-1:0]    rsp_entry_total,
	output logic                         rsp_is_empty,
	output logic [1:0]                   rsp_status
);
	import hpq_pkg::*;

	logic signed [DATA_WIDTH-1:0] mem [CAPACITY];

	logic                         order_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [ADDR_W-1:0]            idx_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic signed [DATA_WIDTH-1:0] root_q;
	logic signed [DATA_WIDTH-1:0] rd_a_q;
	logic signed [DATA_WIDTH-1:0] rd_b_q;
	status_t                      status_q;

	logic signed [DATA_WIDTH-1:0] top_q;
	logic [CNT_W-1:0]             total_q;
	logic                         empty_q;
	status_t                      rstat_q;

	logic [ADDR_W-1:0]            parent_idx;
	logic [CHILD_W-1:0]           child_l;
	logic [CHILD_W-1:0]           child_r;
	logic [CNT_W-1:0]             cnt_dec;
	logic                         right_ok;
	logic                         pick_r;
	logic signed [DATA_WIDTH-1:0] child_val;
	logic [ADDR_W-1:0]            child_idx;

	logic                         rd_en;
	logic [ADDR_W-1:0]            rd_addr_a;
	logic [ADDR_W-1:0]            rd_addr_b;
	logic                         wr_en;
	logic [ADDR_W-1:0]            wr_addr;
	logic signed [DATA_WIDTH-1:0] wr_data;

	// tree index arithmetic
	assign parent_idx = (idx_q - ADDR_W'(1)) >> 1;
	assign child_l    = CHILD_W'({idx_q, 1'b1});
	assign child_r    = child_l + CHILD_W'(1);
	assign cnt_dec    = cnt_q - CNT_W'(1);
	assign right_ok   = child_r < CHILD_W'(cnt_q);

	// child pick, left wins a tie
	assign pick_r    = right_ok && above(rd_b_q, rd_a_q, order_q);
	assign child_val = pick_r ? rd_b_q : rd_a_q;
	assign child_idx = pick_r ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];

	// status to the controller
	assign stat.full     = (cnt_q == CNT_W'(CAPACITY));
	assign stat.empty    = (cnt_q == '0);
	assign stat.last_one = (cnt_q == CNT_W'(1));
	assign stat.at_root  = (idx_q == '0);
	assign stat.up_move  = above(val_q, rd_a_q, order_q);
	assign stat.dn_leaf  = child_l >= CHILD_W'(cnt_q);
	assign stat.dn_move  = above(child_val, val_q, order_q);

	// memory port selection
	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = child_l[ADDR_W-1:0];
		rd_addr_b = child_r[ADDR_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = val_q;
		case (cmd.op)
			OP_DEL_START: begin
				rd_en     = 1'b1;
				rd_addr_a = cnt_dec[ADDR_W-1:0];
			end
			OP_UP_READ: begin
				rd_en     = 1'b1;
				rd_addr_a = parent_idx;
			end
			OP_DN_READ: begin
				rd_en = 1'b1;
			end
			OP_UP_STEP: begin
				wr_en   = 1'b1;
				wr_data = rd_a_q;
			end
			OP_DN_STEP: begin
				wr_en   = 1'b1;
				wr_data = child_val;
			end
			OP_PLACE: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// heap memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	// order mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.op == OP_INS_START) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.op == OP_DEL_START) begin
			cnt_q <= cnt_dec;
		end
	end

	// moving value, hole index, request status
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INS_START: begin
				val_q    <= req_data;
				idx_q    <= cnt_q[ADDR_W-1:0];
				status_q <= STAT_DONE;
			end
			OP_DEL_START: begin
				idx_q    <= '0;
				status_q <= STAT_DONE;
			end
			OP_REJ_FULL: begin
				status_q <= STAT_FULL;
			end
			OP_REJ_EMPTY: begin
				status_q <= STAT_EMPTY;
			end
			OP_DN_LOAD: begin
				val_q <= rd_a_q;
			end
			OP_UP_STEP: begin
				idx_q <= parent_idx;
			end
			OP_DN_STEP: begin
				idx_q <= child_idx;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// copy of the root entry
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			top_q   <= (cnt_q == '0) ? '0 : root_q;
			total_q <= cnt_q;
			empty_q <= (cnt_q == '0);
			rstat_q <= status_q;
		end
	end

	assign rsp_top_value   = top_q;
	assign rsp_entry_total = total_q;
	assign rsp_is_empty    = empty_q;
	assign rsp_status      = rstat_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_up_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_UP_STEP |-> idx_q != '0)
		else $error("sift-up step taken at the root");

	a_dn_descends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DN_STEP |=> idx_q > $past(idx_q))
		else $error("sift-down step did not descend");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load && cnt_q == '0 |=> top_q == '0 && empty_q)
		else $error("empty heap result carries a top value");

endmodule

### rtl/binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top: binary heap priority queue
// Array heap of 1024 signed 32-bit entries, min or max on top.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_type 0 inserts data_value, 1 deletes the top entry.
//   rsp channel: one result per request with the top value after the
//   request (zero when empty), the entry count, an empty flag and a status
//   (done, insert rejected because full, delete ignored because empty).
//   cfg_wr_en / cfg_wr_data write the order mode (0 min on top, 1 max on
//   top); write it only while no request is in flight.
// Timing:
//   one request at a time; req.ready is high only while the sequencer waits.
//   each sift level is a registered memory read, then a compare and write
//   on the single write port. the next request can be taken in the cycle
//   after the result load.
// Reset clears the count (heap empty) and selects min on top.
// A stalled rsp receiver holds the finished result in the output register;
// the next request is still taken and worked, and its result waits until
// the register frees.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top (
	input  logic       clk,
	input  logic       arst_n,
	hpq_req_if.sink    req,
	hpq_rsp_if.source  rsp,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);
	import hpq_pkg::*;

	hpq_cmd_t  cmd;
	hpq_stat_t stat;

	// sequencer
	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// heap storage and result register
	hpq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_data        (req.data_value),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.rsp_top_value   (rsp.top_value),
		.rsp_entry_total (rsp.entry_total),
		.rsp_is_empty    (rsp.is_empty),
		.rsp_status      (rsp.status)
	);

endmodule
